### rtl/cne_pkg.sv
// ----------------------------------------------------------------------------
// cne_pkg
// Types and constants shared by the cell neighbour enumerator modules.
// ----------------------------------------------------------------------------
package cne_pkg;

   localparam int IDX_W      = 24;
   localparam int SIDE_W     = 9;
   localparam int DIMS_W     = 2;
   localparam int SLOT_W     = 5;
   localparam int COORD_W    = 8;
   localparam int W2_W       = 2 * SIDE_W - 1;
   localparam int AXES       = 3;
   localparam int DIGIT_W    = 2;
   localparam int SUM_W      = IDX_W + 2;

   localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(256);
   localparam logic [DIMS_W-1:0] MAX_DIMS = DIMS_W'(3);

   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(16);
   localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(3);

   // radix-8 restoring divider: three quotient bits per cycle
   localparam int STEP_BITS  = 3;
   localparam int DIV_CYCLES = IDX_W / STEP_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SIDE_W;
   localparam logic [CSR_IDX_W-1:0] REG_CELLS_PER_SIDE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_NUM_DIMS       = CSR_IDX_W'(1);

   // base-3 slot digit codes: offset minus one, none, plus one
   localparam logic [DIGIT_W-1:0] DIG_MINUS = DIGIT_W'(0);
   localparam logic [DIGIT_W-1:0] DIG_ZERO  = DIGIT_W'(1);
   localparam logic [DIGIT_W-1:0] DIG_PLUS  = DIGIT_W'(2);

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_HORN,
      F_PUSH
   } front_state_type;

   typedef struct packed {
      logic [IDX_W-1:0]              base;
      logic [AXES-1:0][COORD_W-1:0]  coord;
      logic [SIDE_W-1:0]             side;
      logic [W2_W-1:0]               w2;
      logic [DIMS_W-1:0]             dims;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } push_type;

   typedef struct packed {
      logic     empty;
      desc_type desc;
   } head_type;

endpackage

### rtl/cne_front.sv
// ----------------------------------------------------------------------------
// cne_front
// Takes a cell index, splits it into per-axis coordinates with a radix-8
// divider, rebuilds the in-grid base index and pushes a descriptor.
// ----------------------------------------------------------------------------
module cne_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [cne_pkg::IDX_W-1:0]    cell_index,
   input  logic [cne_pkg::SIDE_W-1:0]   cells_per_side,
   input  logic [cne_pkg::DIMS_W-1:0]   num_dims,
   input  logic                         queue_full,
   output cne_pkg::push_type            push_out
);

   cne_pkg::front_state_type state_ff, state_in;

   logic [cne_pkg::IDX_W-1:0]     quo_ff, quo_in;
   logic [cne_pkg::SIDE_W-1:0]    rem_ff, rem_in;
   logic [cne_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [cne_pkg::DIMS_W-1:0]    axis_ff, axis_in;
   logic [cne_pkg::AXES-1:0][cne_pkg::COORD_W-1:0] coord_ff, coord_in;
   logic [cne_pkg::IDX_W-1:0]     acc_ff, acc_in;
   logic [cne_pkg::SIDE_W-1:0]    side_ff, side_in;
   logic [cne_pkg::W2_W-1:0]      w2_ff, w2_in;
   logic [cne_pkg::DIMS_W-1:0]    dims_ff, dims_in;

   logic [cne_pkg::SIDE_W-1:0]    side_eff;
   logic [cne_pkg::DIMS_W-1:0]    dims_eff;
   logic [cne_pkg::SIDE_W:0]      r_next;
   logic [cne_pkg::IDX_W-1:0]     q_next;
   logic [2*cne_pkg::COORD_W+cne_pkg::SIDE_W-1:0] horn_prod;
   logic                          accept;
   logic                          div_last;
   logic                          axis_last;

   always_comb begin
      if (cells_per_side == '0) begin
         side_eff = cne_pkg::SIDE_W'(1);
      end else if (cells_per_side > cne_pkg::MAX_SIDE) begin
         side_eff = cne_pkg::MAX_SIDE;
      end else begin
         side_eff = cells_per_side;
      end
      if (num_dims == '0) begin
         dims_eff = cne_pkg::DIMS_W'(1);
      end else if (num_dims > cne_pkg::MAX_DIMS) begin
         dims_eff = cne_pkg::MAX_DIMS;
      end else begin
         dims_eff = num_dims;
      end
   end

   // three restoring divide steps; the quotient shifts in behind the dividend
   always_comb begin
      r_next = {1'b0, rem_ff};
      q_next = quo_ff;
      for (int k = 0; k < cne_pkg::STEP_BITS; k++) begin
         r_next = {r_next[cne_pkg::SIDE_W-1:0], q_next[cne_pkg::IDX_W-1]};
         q_next = {q_next[cne_pkg::IDX_W-2:0], 1'b0};
         if (r_next >= {1'b0, side_ff}) begin
            r_next    = r_next - {1'b0, side_ff};
            q_next[0] = 1'b1;
         end
      end
   end

   assign horn_prod = acc_ff[2*cne_pkg::COORD_W-1:0] * side_ff;
   assign div_last  = (cnt_ff == cne_pkg::DIV_CNT_W'(cne_pkg::DIV_CYCLES - 1));
   assign axis_last = (axis_ff == cne_pkg::DIMS_W'(dims_ff - cne_pkg::DIMS_W'(1)));

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      coord_in = coord_ff;
      acc_in   = acc_ff;
      side_in  = side_ff;
      w2_in    = w2_ff;
      dims_in  = dims_ff;

      busy = !((state_ff == cne_pkg::F_IDLE) ||
               ((state_ff == cne_pkg::F_PUSH) && !queue_full));
      accept = start && !busy;

      push_out.valid      = (state_ff == cne_pkg::F_PUSH) && !queue_full;
      push_out.desc.base  = acc_ff;
      push_out.desc.coord = coord_ff;
      push_out.desc.side  = side_ff;
      push_out.desc.w2    = w2_ff;
      push_out.desc.dims  = dims_ff;

      unique case (state_ff)
         cne_pkg::F_IDLE: begin
         end
         cne_pkg::F_DIV: begin
            quo_in = q_next;
            rem_in = r_next[cne_pkg::SIDE_W-1:0];
            cnt_in = cnt_ff + cne_pkg::DIV_CNT_W'(1);
            if (div_last) begin
               coord_in[axis_ff] = r_next[cne_pkg::COORD_W-1:0];
               rem_in = '0;
               cnt_in = '0;
               if (axis_last) begin
                  acc_in = cne_pkg::IDX_W'(r_next[cne_pkg::COORD_W-1:0]);
                  if (axis_ff == '0) begin
                     state_in = cne_pkg::F_PUSH;
                  end else begin
                     axis_in  = axis_ff - cne_pkg::DIMS_W'(1);
                     state_in = cne_pkg::F_HORN;
                  end
               end else begin
                  axis_in = axis_ff + cne_pkg::DIMS_W'(1);
               end
            end
         end
         cne_pkg::F_HORN: begin
            acc_in = cne_pkg::IDX_W'(horn_prod) +
                     cne_pkg::IDX_W'(coord_ff[axis_ff]);
            if (axis_ff == '0) begin
               state_in = cne_pkg::F_PUSH;
            end else begin
               axis_in = axis_ff - cne_pkg::DIMS_W'(1);
            end
         end
         cne_pkg::F_PUSH: begin
            if (!queue_full) begin
               state_in = cne_pkg::F_IDLE;
            end
         end
         default: begin
            state_in = cne_pkg::F_IDLE;
         end
      endcase

      if (accept) begin
         state_in = cne_pkg::F_DIV;
         quo_in   = cell_index;
         rem_in   = '0;
         cnt_in   = '0;
         axis_in  = '0;
         side_in  = side_eff;
         dims_in  = dims_eff;
         w2_in    = cne_pkg::W2_W'(side_eff * side_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cne_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      axis_ff  <= axis_in;
      coord_ff <= coord_in;
      acc_ff   <= acc_in;
      side_ff  <= side_in;
      w2_ff    <= w2_in;
      dims_ff  <= dims_in;
   end

endmodule

### rtl/cne_queue.sv
// ----------------------------------------------------------------------------
// cne_queue
// Short descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module cne_queue (
   input  logic              clock,
   input  logic              reset,
   input  cne_pkg::push_type push_in,
   output logic              full,
   input  logic              pop,
   output cne_pkg::head_type head
);

   localparam int PTR_W = (cne_pkg::QUEUE_DEPTH > 1) ? $clog2(cne_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(cne_pkg::QUEUE_DEPTH + 1);

   cne_pkg::desc_type entry_ff [cne_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(cne_pkg::QUEUE_DEPTH));
   assign head.empty = (count_ff == '0);
   assign head.desc  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && !head.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(cne_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(cne_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + PTR_W'(1);
      end
      if (push_in.valid && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push_in.valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.valid) begin
         entry_ff[wr_ptr_ff] <= push_in.desc;
      end
   end

endmodule

### rtl/cne_back.sv
// ----------------------------------------------------------------------------
// cne_back
// Walks the 3^dims neighbourhood of one descriptor, one slot per cycle,
// and registers each result.
// ----------------------------------------------------------------------------
module cne_back (
   input  logic                        clock,
   input  logic                        reset,
   input  cne_pkg::head_type           head,
   output logic                        pop,
   output logic                        rsp_strobe,
   output logic [cne_pkg::SLOT_W-1:0]  rsp_slot,
   output logic                        rsp_neighbor_valid,
   output logic [cne_pkg::IDX_W-1:0]   rsp_neighbor_index,
   output logic                        rsp_last
);

   logic                                         active_ff, active_in;
   cne_pkg::desc_type                            cur_ff, cur_in;
   logic [cne_pkg::AXES-1:0][cne_pkg::DIGIT_W-1:0] dig_ff, dig_in;
   logic [cne_pkg::SLOT_W-1:0]                   slot_ff, slot_in;

   logic                         strobe_ff;
   logic [cne_pkg::SLOT_W-1:0]   slot_out_ff;
   logic                         valid_out_ff;
   logic [cne_pkg::IDX_W-1:0]    index_out_ff;
   logic                         last_out_ff;

   logic [cne_pkg::AXES-1:0][cne_pkg::W2_W-1:0] wt;
   logic signed [cne_pkg::SUM_W-1:0] idx_sum;
   logic                             ok;
   logic                             last_now;
   logic                             used;
   logic                             carry;

   always_comb begin
      wt[0] = cne_pkg::W2_W'(1);
      wt[1] = cne_pkg::W2_W'(cur_ff.side);
      wt[2] = cur_ff.w2;

      ok       = 1'b1;
      last_now = 1'b1;
      idx_sum  = cne_pkg::SUM_W'(cur_ff.base);
      for (int d = 0; d < cne_pkg::AXES; d++) begin
         used = (cne_pkg::DIMS_W'(d) < cur_ff.dims);
         if (used) begin
            if (dig_ff[d] != cne_pkg::DIG_PLUS) begin
               last_now = 1'b0;
            end
            case (dig_ff[d])
               cne_pkg::DIG_MINUS: begin
                  if (cur_ff.coord[d] == '0) begin
                     ok = 1'b0;
                  end
                  idx_sum = idx_sum - cne_pkg::SUM_W'(wt[d]);
               end
               cne_pkg::DIG_PLUS: begin
                  if ((cne_pkg::SIDE_W'(cur_ff.coord[d]) + cne_pkg::SIDE_W'(1))
                      >= cur_ff.side) begin
                     ok = 1'b0;
                  end
                  idx_sum = idx_sum + cne_pkg::SUM_W'(wt[d]);
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign pop = !head.empty && (!active_ff || last_now);

   always_comb begin
      active_in = active_ff;
      cur_in    = cur_ff;
      slot_in   = slot_ff + cne_pkg::SLOT_W'(1);
      dig_in    = dig_ff;

      // base-3 increment of the slot digits
      carry = 1'b1;
      for (int d = 0; d < cne_pkg::AXES; d++) begin
         if (carry) begin
            if (dig_ff[d] == cne_pkg::DIG_PLUS) begin
               dig_in[d] = cne_pkg::DIG_MINUS;
            end else begin
               dig_in[d] = dig_ff[d] + cne_pkg::DIGIT_W'(1);
               carry     = 1'b0;
            end
         end
      end

      if (active_ff && last_now) begin
         active_in = 1'b0;
      end
      if (pop) begin
         active_in = 1'b1;
         cur_in    = head.desc;
         slot_in   = '0;
         dig_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= active_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      dig_ff       <= dig_in;
      slot_ff      <= slot_in;
      slot_out_ff  <= slot_ff;
      valid_out_ff <= ok;
      index_out_ff <= ok ? idx_sum[cne_pkg::IDX_W-1:0] : '0;
      last_out_ff  <= last_now;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_slot           = slot_out_ff;
   assign rsp_neighbor_valid = valid_out_ff;
   assign rsp_neighbor_index = index_out_ff;
   assign rsp_last           = last_out_ff;

endmodule

### rtl/cell_neighbor_enumerator_top.sv
// Results: one result per cycle for the 3^dims slots of each cell, once the
//   back has taken its descriptor from the queue.
// Throughput: the front is paced by its radix-8 divider and stays busy until
//   it can push the descriptor of the current cell to the queue.
// Results come as strobed one-cycle beats; the receiver cannot stall.
// Reset (synchronous, active high) empties the queue and restores 16 x 3.
// ----------------------------------------------------------------------------
// cell_neighbor_enumerator_top
// Enumerates the neighbour cells of a grid cell in slot order.
// ----------------------------------------------------------------------------
module cell_neighbor_enumerator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [cne_pkg::IDX_W-1:0]       req_cell_index,
   output logic                            rsp_strobe,
   output logic [cne_pkg::SLOT_W-1:0]      rsp_slot,
   output logic                            rsp_neighbor_valid,
   output logic [cne_pkg::IDX_W-1:0]       rsp_neighbor_index,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cne_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cne_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [cne_pkg::SIDE_W-1:0] cells_per_side_ff, cells_per_side_in;
   logic [cne_pkg::DIMS_W-1:0] num_dims_ff, num_dims_in;

   cne_pkg::push_type push;
   cne_pkg::head_type head;
   logic              queue_full;
   logic              pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cells_per_side_in = cells_per_side_ff;
      num_dims_in       = num_dims_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cne_pkg::REG_CELLS_PER_SIDE: begin
               cells_per_side_in = csr_wdata[cne_pkg::SIDE_W-1:0];
            end
            cne_pkg::REG_NUM_DIMS: begin
               num_dims_in = csr_wdata[cne_pkg::DIMS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_per_side_ff <= cne_pkg::SIDE_RESET;
         num_dims_ff       <= cne_pkg::DIMS_RESET;
      end else begin
         cells_per_side_ff <= cells_per_side_in;
         num_dims_ff       <= num_dims_in;
      end
   end

   cne_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .cell_index     (req_cell_index),
      .cells_per_side (cells_per_side_ff),
      .num_dims       (num_dims_ff),
      .queue_full     (queue_full),
      .push_out       (push)
   );

   cne_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .full    (queue_full),
      .pop     (pop),
      .head    (head)
   );

   cne_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_slot           (rsp_slot),
      .rsp_neighbor_valid (rsp_neighbor_valid),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_last           (rsp_last)
   );

endmodule

### test/cell_neighbor_enumerator_top_test.sv
// ----------------------------------------------------------------------------
// cell_neighbor_enumerator_top_test
// Drives centre cells into the enumerator under a range of grid settings and
// checks every neighbour beat against a local prediction of the neighbourhood.
// ----------------------------------------------------------------------------
module cell_neighbor_enumerator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cne_pkg::CSR_IDX_W-1:0] REG_UNMAPPED = cne_pkg::CSR_IDX_W'(2);
   localparam int RANDOM_PHASES    = 12;
   localparam int CELLS_PER_PHASE  = 38;
   localparam int SETTLE_CYCLES    = 40;

   typedef struct {
      logic [cne_pkg::SLOT_W-1:0] slot;
      logic                       valid;
      logic [cne_pkg::IDX_W-1:0]  index;
      logic                       last;
   } neighbour_type;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [cne_pkg::IDX_W-1:0]      req_cell_index;
   logic                           rsp_strobe;
   logic [cne_pkg::SLOT_W-1:0]     rsp_slot;
   logic                           rsp_neighbor_valid;
   logic [cne_pkg::IDX_W-1:0]      rsp_neighbor_index;
   logic                           rsp_last;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [cne_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [cne_pkg::CSR_DATA_W-1:0] csr_wdata;

   // grid settings as the block should hold them
   logic [cne_pkg::SIDE_W-1:0]     side_reg;
   logic [cne_pkg::DIMS_W-1:0]     dims_reg;

   neighbour_type         awaited_neighbours[$];
   bit                    zero_gaps;
   int                    failures;
   int                    cells_sent;
   int                    neighbours_seen;
   int                    settings_used;

   cell_neighbor_enumerator_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cell_index     (req_cell_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_slot           (rsp_slot),
      .rsp_neighbor_valid (rsp_neighbor_valid),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("%0t: timeout, %0d neighbours still awaited", $time,
               awaited_neighbours.size());
      $display("simulation failed");
      $finish;
   end

   // Work out the full neighbourhood of one centre cell and queue it.
   task automatic predict_neighbours(input logic [cne_pkg::IDX_W-1:0] centre);
      int unsigned   side;
      int unsigned   dims;
      int unsigned   rest;
      int unsigned   coord[cne_pkg::AXES];
      int unsigned   nslots;
      int unsigned   digits;
      int unsigned   dig;
      int unsigned   idx;
      int unsigned   weight;
      bit            ok;
      neighbour_type n;
      side = (side_reg == 0) ? 1 :
             (side_reg > cne_pkg::MAX_SIDE) ? cne_pkg::MAX_SIDE : side_reg;
      dims = (dims_reg == 0) ? 1 :
             (dims_reg > cne_pkg::MAX_DIMS) ? cne_pkg::MAX_DIMS : dims_reg;
      rest = centre;
      nslots = 1;
      for (int d = 0; d < cne_pkg::AXES; d++) coord[d] = 0;
      // quotient left after the last axis is dropped
      for (int d = 0; d < dims; d++) begin
         coord[d] = rest % side;
         rest = rest / side;
         nslots = nslots * 3;
      end
      for (int unsigned s = 0; s < nslots; s++) begin
         digits = s;
         idx = 0;
         weight = 1;
         ok = 1'b1;
         for (int d = 0; d < dims; d++) begin
            dig = digits % 3;
            digits = digits / 3;
            if (dig == cne_pkg::DIG_MINUS && coord[d] == 0) ok = 1'b0;
            if (dig == cne_pkg::DIG_PLUS && coord[d] + 1 >= side) ok = 1'b0;
            if (ok) idx = idx + (coord[d] + dig - 1) * weight;
            weight = weight * side;
         end
         n.slot  = cne_pkg::SLOT_W'(s);
         n.valid = ok;
         n.index = ok ? idx[cne_pkg::IDX_W-1:0] : '0;
         n.last  = (s + 1 == nslots);
         awaited_neighbours.push_back(n);
      end
   endtask

   // One register beat; hold valid high when another write follows at once.
   task automatic set_register(input logic [cne_pkg::CSR_IDX_W-1:0] index,
                               input logic [cne_pkg::CSR_DATA_W-1:0] data,
                               input bit hold);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (!hold) csr_valid <= 1'b0;
      if (index == cne_pkg::REG_CELLS_PER_SIDE) side_reg = data;
      else if (index == cne_pkg::REG_NUM_DIMS) dims_reg = data[cne_pkg::DIMS_W-1:0];
   endtask

   task automatic set_grid(input logic [cne_pkg::CSR_DATA_W-1:0] side,
                           input logic [cne_pkg::CSR_DATA_W-1:0] dims_word);
      set_register(cne_pkg::REG_CELLS_PER_SIDE, side, 1'b1);
      set_register(cne_pkg::REG_NUM_DIMS, dims_word, 1'b0);
      settings_used++;
   endtask

   task automatic send_cell(input logic [cne_pkg::IDX_W-1:0] centre);
      int unsigned gap;
      gap = zero_gaps ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cell_index <= centre;
      do @(posedge clock); while (busy);
      predict_neighbours(centre);
      cells_sent++;
   endtask

   // Drop start and wait for every neighbour of the burst to come back.
   task automatic drain;
      start <= 1'b0;
      while (awaited_neighbours.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_neighbours
      neighbour_type want;
      if (!reset && rsp_strobe) begin
         neighbours_seen++;
         if (awaited_neighbours.size() == 0) begin
            $display("%0t: unexpected beat slot %0d valid %0b index %0d last %0b",
                     $time, rsp_slot, rsp_neighbor_valid, rsp_neighbor_index, rsp_last);
            failures++;
         end else begin
            want = awaited_neighbours.pop_front();
            if (rsp_slot !== want.slot || rsp_neighbor_valid !== want.valid ||
                rsp_neighbor_index !== want.index || rsp_last !== want.last) begin
               $display("%0t: expected slot %0d valid %0b index %0d last %0b, got %0d %0b %0d %0b",
                        $time, want.slot, want.valid, want.index, want.last,
                        rsp_slot, rsp_neighbor_valid, rsp_neighbor_index, rsp_last);
               failures++;
            end
         end
      end
   end

   task automatic test_reset_grid;
      send_cell(cne_pkg::IDX_W'(0));
      send_cell(cne_pkg::IDX_W'(4095));
      send_cell(cne_pkg::IDX_W'(8 + 8 * 16 + 8 * 256));
      send_cell(cne_pkg::IDX_W'('hFFFFFF));
      send_cell(cne_pkg::IDX_W'('hABC123));
      drain();
   endtask

   task automatic test_side_extremes;
      set_grid(cne_pkg::CSR_DATA_W'(256), cne_pkg::CSR_DATA_W'(3));
      send_cell(cne_pkg::IDX_W'('hFFFFFF));
      send_cell(cne_pkg::IDX_W'('h018001));
      drain();
      set_grid(cne_pkg::CSR_DATA_W'(1), cne_pkg::CSR_DATA_W'(3));
      send_cell(cne_pkg::IDX_W'(0));
      send_cell(cne_pkg::IDX_W'('hFFFFFF));
      drain();
      // zero side behaves as a single cell
      set_grid(cne_pkg::CSR_DATA_W'(0), cne_pkg::CSR_DATA_W'(3));
      send_cell(cne_pkg::IDX_W'(5));
      send_cell(cne_pkg::IDX_W'('h800000));
      drain();
      // oversize side clamps to the maximum
      set_grid(cne_pkg::CSR_DATA_W'(511), cne_pkg::CSR_DATA_W'(2));
      send_cell(cne_pkg::IDX_W'('h00FF00));
      send_cell(cne_pkg::IDX_W'('h0000FF));
      drain();
   endtask

   task automatic test_dim_counts;
      set_grid(cne_pkg::CSR_DATA_W'(7), cne_pkg::CSR_DATA_W'(1));
      send_cell(cne_pkg::IDX_W'(0));
      send_cell(cne_pkg::IDX_W'(6));
      drain();
      // zero dimensions behave as one; upper data bits are ignored
      set_grid(cne_pkg::CSR_DATA_W'(7), {7'h7F, 2'b00});
      send_cell(cne_pkg::IDX_W'(3));
      send_cell(cne_pkg::IDX_W'('hFFFFFE));
      drain();
      set_grid(cne_pkg::CSR_DATA_W'(4), cne_pkg::CSR_DATA_W'(2));
      send_cell(cne_pkg::IDX_W'(5));
      send_cell(cne_pkg::IDX_W'(15));
      drain();
      // a write to an unmapped index must leave the grid alone
      set_register(REG_UNMAPPED, cne_pkg::CSR_DATA_W'('h1FF), 1'b0);
      send_cell(cne_pkg::IDX_W'(10));
      drain();
   endtask

   task automatic test_random_traffic;
      int unsigned side;
      int unsigned dims;
      int unsigned eff_side;
      int unsigned eff_dims;
      int unsigned centre;
      int unsigned weight;
      int unsigned c;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0: side = 1;
            1: side = 2;
            2: side = $urandom_range(3, 8);
            3: side = $urandom_range(1, 256);
            4: side = 256;
            default: side = $urandom_range(0, 511);
         endcase
         dims = $urandom_range(0, 3);
         set_grid(cne_pkg::CSR_DATA_W'(side), {7'($urandom_range(0, 127)), 2'(dims)});
         eff_side = (side == 0) ? 1 : (side > 256) ? 256 : side;
         eff_dims = (dims == 0) ? 1 : dims;
         zero_gaps = (p % 3 == 0);
         for (int i = 0; i < CELLS_PER_PHASE; i++) begin
            if ($urandom_range(0, 4) == 0) begin
               centre = $urandom;
            end else begin
               // in-grid cell, biased towards the faces of the grid
               centre = 0;
               weight = 1;
               for (int d = 0; d < eff_dims; d++) begin
                  case ($urandom_range(0, 3))
                     0: c = 0;
                     1: c = eff_side - 1;
                     default: c = $urandom_range(0, eff_side - 1);
                  endcase
                  centre = centre + c * weight;
                  weight = weight * eff_side;
               end
            end
            send_cell(centre[cne_pkg::IDX_W-1:0]);
         end
         drain();
      end
      zero_gaps = 1'b0;
   endtask

   initial begin
      side_reg = cne_pkg::SIDE_RESET;
      dims_reg = cne_pkg::DIMS_RESET;
      failures = 0;
      cells_sent = 0;
      neighbours_seen = 0;
      settings_used = 1;
      zero_gaps = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_cell_index <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_grid();
      test_side_extremes();
      test_dim_counts();
      test_random_traffic();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_neighbours.size() != 0) begin
         $display("%0t: %0d neighbours never arrived", $time, awaited_neighbours.size());
         failures++;
      end
      $display("Sent %0d centre cells under %0d grid settings, checked %0d neighbours.",
               cells_sent, settings_used, neighbours_seen);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
